// ----- sv/pifp_pkg.sv -----
package pifp_pkg;

   // operation select carried on the request channel
   typedef enum logic {
      FUNC_ENCODE = 1'b0,
      FUNC_DECODE = 1'b1
   } func_type;

   // double layout
   localparam int unsigned WORD_W  = 64;
   localparam int unsigned FRAC_W  = 52;
   localparam int unsigned EXP_W   = 11;
   localparam int unsigned IDX_W   = 24;
   localparam int unsigned PART_W  = 12;
   localparam int unsigned SHIFT_W = 6;

   // exponent of 1.0 and of the smallest fraction step (2^-52)
   localparam logic [EXP_W-1:0] EXP_BIAS = 11'd1023;
   localparam logic [EXP_W-1:0] EXP_MIN  = 11'd971;

   // largest fraction below one
   localparam logic [FRAC_W-1:0] FRAC_NEAR_ONE = 52'hF_FFFF_FFFF_FFFF;

   // one word's worth of work for the converter
   typedef struct packed {
      func_type          func;
      logic [WORD_W-1:0] word;
      logic [PART_W-1:0] idx_part;
   } conv_in_type;

endpackage

// ----- sv/patch_index_fixed_point_pack_unit.sv -----
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    func, first_word, second_word, index_in
// rsp_      out        rsp_valid/stall    first_out, second_out, index_out
//
// One transaction per cycle sustained while rsp_stall stays low.
// Input register, one pass of shift and leading-one detect, result register.
// Synchronous active-high reset clears both valid flags; payload is not reset.
// A stalled result holds; the input register still takes a transaction while
// the result register is full, and req_stall rises only when both are full.
module patch_index_fixed_point_pack_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [pifp_pkg::WORD_W-1:0]   req_first_word,
   input  logic [pifp_pkg::WORD_W-1:0]   req_second_word,
   input  logic [pifp_pkg::IDX_W-1:0]    req_index_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pifp_pkg::WORD_W-1:0]   rsp_first_out,
   output logic [pifp_pkg::WORD_W-1:0]   rsp_second_out,
   output logic [pifp_pkg::IDX_W-1:0]    rsp_index_out
);

   logic                          in_valid_ff, in_valid_in;
   pifp_pkg::func_type            in_func_ff;
   logic [pifp_pkg::WORD_W-1:0]   in_first_ff, in_second_ff;
   logic [pifp_pkg::IDX_W-1:0]    in_index_ff;

   logic                          out_valid_ff, out_valid_in;
   pifp_pkg::func_type            out_func_ff, out_func_in;
   logic [pifp_pkg::WORD_W-1:0]   out_first_ff, out_first_in;
   logic [pifp_pkg::WORD_W-1:0]   out_second_ff, out_second_in;
   logic [pifp_pkg::IDX_W-1:0]    out_index_ff, out_index_in;

   logic                          out_load;
   logic                          in_load;
   pifp_pkg::conv_in_type         conv_first, conv_second;

   // flow control
   assign out_load  = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !out_load;
   assign in_load   = req_valid && !req_stall;

   assign in_valid_in  = (in_valid_ff && !out_load) || in_load;
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_func_ff   <= pifp_pkg::func_type'(req_func);
         in_first_ff  <= req_first_word;
         in_second_ff <= req_second_word;
         in_index_ff  <= req_index_in;
      end
   end

   // per-word conversion
   assign conv_first = '{func:     in_func_ff,
                         word:     in_first_ff,
                         idx_part: in_index_ff[pifp_pkg::PART_W-1:0]};
   assign conv_second = '{func:     in_func_ff,
                          word:     in_second_ff,
                          idx_part: in_index_ff[pifp_pkg::IDX_W-1:pifp_pkg::PART_W]};

   pifp_conv u_conv_first (
      .conv_in  (conv_first),
      .conv_out (out_first_in)
   );

   pifp_conv u_conv_second (
      .conv_in  (conv_second),
      .conv_out (out_second_in)
   );

   // on decode, index recovered from the top twelve bits of each packed word; encode gives zero
   always_comb begin
      case (in_func_ff)
         pifp_pkg::FUNC_ENCODE: out_index_in = '0;
         pifp_pkg::FUNC_DECODE: out_index_in =
            {in_second_ff[pifp_pkg::WORD_W-1:pifp_pkg::FRAC_W],
             in_first_ff[pifp_pkg::WORD_W-1:pifp_pkg::FRAC_W]};
         default:               out_index_in = '0;
      endcase
   end

   assign out_func_in = in_func_ff;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && in_valid_ff) begin
         out_func_ff   <= out_func_in;
         out_first_ff  <= out_first_in;
         out_second_ff <= out_second_in;
         out_index_ff  <= out_index_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_first_out  = out_first_ff;
   assign rsp_second_out = out_second_ff;
   assign rsp_index_out  = out_index_ff;

   // checks
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_load) |=> out_valid_ff)
      else $error("transaction lost between input and result register");

   a_encode_index_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_func_ff == pifp_pkg::FUNC_ENCODE)) |-> (out_index_ff == '0))
      else $error("encode result carries a non-zero index");

   a_decode_positive: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_func_ff == pifp_pkg::FUNC_DECODE))
         |-> (!out_first_ff[pifp_pkg::WORD_W-1] && !out_second_ff[pifp_pkg::WORD_W-1]))
      else $error("decoded double has its sign set");

   a_decode_exp_range: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_func_ff == pifp_pkg::FUNC_DECODE))
         |-> ((out_first_ff == '0)
              || ((out_first_ff[pifp_pkg::WORD_W-2:pifp_pkg::FRAC_W] >= pifp_pkg::EXP_MIN)
                  && (out_first_ff[pifp_pkg::WORD_W-2:pifp_pkg::FRAC_W] < pifp_pkg::EXP_BIAS))))
      else $error("decoded exponent outside the unit interval");

endmodule

// ----- sv/pifp_conv.sv -----
module pifp_conv (
   input  pifp_pkg::conv_in_type           conv_in,
   output logic [pifp_pkg::WORD_W-1:0]     conv_out
);

   logic                              sign_bit;
   logic [pifp_pkg::EXP_W-1:0]        enc_exp;
   logic [pifp_pkg::EXP_W-1:0]        enc_diff;
   logic [pifp_pkg::SHIFT_W-1:0]      enc_shift;
   logic [pifp_pkg::FRAC_W:0]         enc_mant;
   logic [pifp_pkg::FRAC_W:0]         enc_shifted;
   logic [pifp_pkg::FRAC_W-1:0]       enc_frac;
   logic [pifp_pkg::FRAC_W-1:0]       dec_frac;
   logic [pifp_pkg::SHIFT_W-1:0]      lead_pos;
   logic [pifp_pkg::SHIFT_W-1:0]      dec_shift;
   logic [pifp_pkg::FRAC_W-1:0]       dec_mant;
   logic [pifp_pkg::EXP_W-1:0]        dec_exp;
   logic [pifp_pkg::WORD_W-1:0]       dec_word;

   // encode: double to truncated unsigned fraction
   assign sign_bit  = conv_in.word[pifp_pkg::WORD_W-1];
   assign enc_exp   = conv_in.word[pifp_pkg::WORD_W-2:pifp_pkg::FRAC_W];
   assign enc_mant  = {1'b1, conv_in.word[pifp_pkg::FRAC_W-1:0]};
   assign enc_diff  = pifp_pkg::EXP_BIAS - enc_exp;
   assign enc_shift = enc_diff[pifp_pkg::SHIFT_W-1:0];
   assign enc_shifted = enc_mant >> enc_shift;

   always_comb begin
      if (sign_bit || (enc_exp < pifp_pkg::EXP_MIN)) begin
         enc_frac = '0;
      end else if (enc_exp >= pifp_pkg::EXP_BIAS) begin
         // one and above, infinity and NaN clamp just below one
         enc_frac = pifp_pkg::FRAC_NEAR_ONE;
      end else begin
         enc_frac = enc_shifted[pifp_pkg::FRAC_W-1:0];
      end
   end

   // decode: leading-one detect, highest set bit wins
   assign dec_frac = conv_in.word[pifp_pkg::FRAC_W-1:0];

   always_comb begin
      lead_pos = '0;
      for (int i = 0; i < pifp_pkg::FRAC_W; i++) begin
         if (dec_frac[i]) begin
            lead_pos = pifp_pkg::SHIFT_W'(i);
         end
      end
   end

   assign dec_shift = pifp_pkg::SHIFT_W'(pifp_pkg::FRAC_W) - lead_pos;
   assign dec_mant  = dec_frac << dec_shift;
   assign dec_exp   = pifp_pkg::EXP_MIN + {{(pifp_pkg::EXP_W-pifp_pkg::SHIFT_W){1'b0}}, lead_pos};

   // zero fraction restores to +0.0
   assign dec_word = (dec_frac == '0) ? '0 : {1'b0, dec_exp, dec_mant};

   // result select
   always_comb begin
      case (conv_in.func)
         pifp_pkg::FUNC_ENCODE: conv_out = {conv_in.idx_part, enc_frac};
         pifp_pkg::FUNC_DECODE: conv_out = dec_word;
         default:               conv_out = '0;
      endcase
   end

endmodule

// ----- sim/patch_index_fixed_point_pack_unit_tb.sv -----
module patch_index_fixed_point_pack_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   // one request transaction as queued for the driver
   typedef struct {
      pifp_pkg::func_type          func;
      logic [pifp_pkg::WORD_W-1:0] first_word;
      logic [pifp_pkg::WORD_W-1:0] second_word;
      logic [pifp_pkg::IDX_W-1:0]  index_in;
   } pack_request_type;

   // one result transaction as predicted
   typedef struct {
      logic [pifp_pkg::WORD_W-1:0] first_out;
      logic [pifp_pkg::WORD_W-1:0] second_out;
      logic [pifp_pkg::IDX_W-1:0]  index_out;
   } pack_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_func = 1'b0;
   logic [pifp_pkg::WORD_W-1:0] req_first_word = '0;
   logic [pifp_pkg::WORD_W-1:0] req_second_word = '0;
   logic [pifp_pkg::IDX_W-1:0]  req_index_in = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [pifp_pkg::WORD_W-1:0] rsp_first_out;
   logic [pifp_pkg::WORD_W-1:0] rsp_second_out;
   logic [pifp_pkg::IDX_W-1:0]  rsp_index_out;

   pack_request_type queued_requests[$];
   pack_result_type  awaited_results[$];

   int          error_count = 0;
   int          accepted_count = 0;
   int          checked_count = 0;
   int          encode_count = 0;
   int          decode_count = 0;
   int          total_items = 0;
   bit          calm = 1'b0;

   patch_index_fixed_point_pack_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_first_word  (req_first_word),
      .req_second_word (req_second_word),
      .req_index_in    (req_index_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_first_out   (rsp_first_out),
      .rsp_second_out  (rsp_second_out),
      .rsp_index_out   (rsp_index_out)
   );

   // clock, 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // double bits to unit-interval fraction, truncating
   function automatic logic [pifp_pkg::FRAC_W-1:0] double_to_frac(
         logic [pifp_pkg::WORD_W-1:0] bits);
      logic [pifp_pkg::EXP_W-1:0]  e;
      logic [pifp_pkg::FRAC_W:0]   m;
      if (bits[pifp_pkg::WORD_W-1])
         return '0;
      e = bits[62:52];
      if (e < pifp_pkg::EXP_MIN)
         return '0;
      if (e >= pifp_pkg::EXP_BIAS)
         return pifp_pkg::FRAC_NEAR_ONE;
      m = {1'b1, bits[pifp_pkg::FRAC_W-1:0]};
      return pifp_pkg::FRAC_W'(m >> (pifp_pkg::EXP_BIAS - e));
   endfunction

   // fraction back to double bits via leading-one position
   function automatic logic [pifp_pkg::WORD_W-1:0] frac_to_double(
         logic [pifp_pkg::WORD_W-1:0] word);
      logic [pifp_pkg::FRAC_W-1:0] f;
      logic [pifp_pkg::FRAC_W-1:0] mant;
      logic [pifp_pkg::EXP_W-1:0]  e;
      int                          p;
      f = word[pifp_pkg::FRAC_W-1:0];
      p = 0;
      if (f == '0)
         return '0;
      for (int i = 0; i < pifp_pkg::FRAC_W; i++)
         if (f[i])
            p = i;
      mant = f << (pifp_pkg::FRAC_W - p);
      e = pifp_pkg::EXP_MIN + pifp_pkg::EXP_W'(p);
      return {1'b0, e, mant};
   endfunction

   function automatic pack_result_type convert_request(pifp_pkg::func_type func,
                                                       logic [pifp_pkg::WORD_W-1:0] w0,
                                                       logic [pifp_pkg::WORD_W-1:0] w1,
                                                       logic [pifp_pkg::IDX_W-1:0] idx);
      pack_result_type r;
      if (func == pifp_pkg::FUNC_ENCODE) begin
         r.first_out  = {idx[pifp_pkg::PART_W-1:0], double_to_frac(w0)};
         r.second_out = {idx[pifp_pkg::IDX_W-1:pifp_pkg::PART_W], double_to_frac(w1)};
         r.index_out  = '0;
      end else begin
         r.first_out  = frac_to_double(w0);
         r.second_out = frac_to_double(w1);
         r.index_out  = {w1[63:52], w0[63:52]};
      end
      return r;
   endfunction

   task automatic add_request(pifp_pkg::func_type func, logic [pifp_pkg::WORD_W-1:0] w0,
                              logic [pifp_pkg::WORD_W-1:0] w1,
                              logic [pifp_pkg::IDX_W-1:0] idx);
      pack_request_type q;
      q.func        = func;
      q.first_word  = w0;
      q.second_word = w1;
      q.index_in    = idx;
      queued_requests.push_back(q);
   endtask

   task automatic report_mismatch(string field, logic [pifp_pkg::WORD_W-1:0] want,
                                  logic [pifp_pkg::WORD_W-1:0] got);
      $display("mismatch on %s at transaction %0d: expected %h, got %h",
               field, checked_count, want, got);
      error_count++;
   endtask

   function automatic logic [pifp_pkg::WORD_W-1:0] random_word();
      return {$urandom(), $urandom()};
   endfunction

   // doubles weighted towards the exponents that land inside the fraction range
   function automatic logic [pifp_pkg::WORD_W-1:0] random_double();
      logic                        sign;
      logic [pifp_pkg::EXP_W-1:0]  e;
      logic [pifp_pkg::WORD_W-1:0] raw;
      raw  = random_word();
      sign = ($urandom_range(0, 7) == 0) ? raw[63] : 1'b0;
      case ($urandom_range(0, 9))
         0:       e = raw[62:52];
         1:       e = pifp_pkg::EXP_W'($urandom_range(1023, 2047));
         2:       e = pifp_pkg::EXP_W'($urandom_range(0, 970));
         default: e = pifp_pkg::EXP_W'($urandom_range(966, 1026));
      endcase
      return {sign, e, raw[pifp_pkg::FRAC_W-1:0]};
   endfunction

   // packed words with the leading one spread across every position
   function automatic logic [pifp_pkg::WORD_W-1:0] random_packed();
      logic [pifp_pkg::WORD_W-1:0] raw;
      logic [pifp_pkg::FRAC_W-1:0] f;
      raw = random_word();
      f   = raw[pifp_pkg::FRAC_W-1:0] >> $urandom_range(0, pifp_pkg::FRAC_W);
      return {raw[63:52], f};
   endfunction

   // driver: next request goes out once the current one is taken
   always @(posedge clock) begin
      int               send_gap;
      int               idle_odds;
      int               cycle_no;
      pack_request_type q;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
         idle_odds = 4;
         cycle_no  = 0;
      end else begin
         cycle_no++;
         if (cycle_no % 128 == 0)
            idle_odds = $urandom_range(0, 6);
         if (req_valid && !req_stall) begin
            awaited_results.push_back(convert_request(pifp_pkg::func_type'(req_func),
                                                      req_first_word, req_second_word,
                                                      req_index_in));
            accepted_count++;
            if (req_func == pifp_pkg::FUNC_ENCODE)
               encode_count++;
            else
               decode_count++;
         end
         if (!req_valid || !req_stall) begin
            calm = (queued_requests.size() < 150);
            if (!calm && send_gap == 0 && idle_odds != 0 && $urandom_range(0, 9) < idle_odds)
               send_gap = $urandom_range(1, 12);
            if (send_gap > 0 && !calm) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (queued_requests.size() > 0) begin
               send_gap = 0;
               q = queued_requests.pop_front();
               req_valid       <= 1'b1;
               req_func        <= q.func;
               req_first_word  <= q.first_word;
               req_second_word <= q.second_word;
               req_index_in    <= q.index_in;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each taken result with the oldest prediction
   always @(posedge clock) begin
      int              stall_left;
      int              stall_odds;
      int              cycle_no;
      pack_result_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
         stall_odds = 3;
         cycle_no   = 0;
      end else begin
         cycle_no++;
         if (cycle_no % 96 == 0)
            stall_odds = $urandom_range(0, 6);
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("unexpected result", '0, rsp_first_out);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_first_out !== want.first_out)
                  report_mismatch("first_out", want.first_out, rsp_first_out);
               if (rsp_second_out !== want.second_out)
                  report_mismatch("second_out", want.second_out, rsp_second_out);
               if (rsp_index_out !== want.index_out)
                  report_mismatch("index_out", pifp_pkg::WORD_W'(want.index_out),
                                  pifp_pkg::WORD_W'(rsp_index_out));
            end
            checked_count++;
         end
         if (calm) begin
            stall_left = 0;
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (stall_odds != 0 && $urandom_range(0, 9) < stall_odds) begin
            stall_left = $urandom_range(1, 12) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // stimulus and end of run
   initial begin
      // encode: zeros, signs, clamps, thresholds, index extremes
      add_request(pifp_pkg::FUNC_ENCODE, 64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                  24'h000000);
      add_request(pifp_pkg::FUNC_ENCODE, 64'h3FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                  24'hFFFFFF);
      add_request(pifp_pkg::FUNC_ENCODE, 64'h7FF8_0000_0000_0001, 64'hFFF0_0000_0000_0000,
                  24'hABC123);
      add_request(pifp_pkg::FUNC_ENCODE, 64'h3FEF_FFFF_FFFF_FFFF, 64'h3FE0_0000_0000_0000,
                  24'h555AAA);
      add_request(pifp_pkg::FUNC_ENCODE, 64'h3CB0_0000_0000_0000, 64'h3CAF_FFFF_FFFF_FFFF,
                  24'hAAA555);
      add_request(pifp_pkg::FUNC_ENCODE, 64'h000F_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
                  24'h000FFF);
      add_request(pifp_pkg::FUNC_ENCODE, 64'hBFE0_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                  24'hFFF000);
      add_request(pifp_pkg::FUNC_ENCODE, 64'h7FEF_FFFF_FFFF_FFFF, 64'h3CBF_FFFF_FFFF_FFFF,
                  24'h800001);
      add_request(pifp_pkg::FUNC_ENCODE, 64'h3FDF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0001,
                  24'h7FFFFE);
      add_request(pifp_pkg::FUNC_ENCODE, 64'h7FFF_FFFF_FFFF_FFFF, 64'h3FE5_5555_5555_5555,
                  24'h123456);
      // decode: zero fraction, smallest and largest fraction, single top bit
      add_request(pifp_pkg::FUNC_DECODE, 64'h0000_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                  24'hFFFFFF);
      add_request(pifp_pkg::FUNC_DECODE, 64'h0000_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF,
                  24'h000000);
      add_request(pifp_pkg::FUNC_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0008_0000_0000_0000,
                  24'h5A5A5A);
      add_request(pifp_pkg::FUNC_DECODE, 64'hABC0_0000_0000_0002, 64'h1230_0000_0000_0003,
                  24'hA5A5A5);
      add_request(pifp_pkg::FUNC_DECODE, 64'h5550_AAAA_AAAA_AAAA, 64'hAAA5_5555_5555_5555,
                  24'h000001);
      add_request(pifp_pkg::FUNC_DECODE, 64'hFFF0_0000_0000_0000, 64'h0000_0000_0000_0000,
                  24'h800000);
      add_request(pifp_pkg::FUNC_DECODE, 64'h000F_FFFF_FFFF_FFFE, 64'h0004_0000_0000_0000,
                  24'hFFFFFF);

      // random part, mostly meaningful doubles and spread fractions
      for (int n = 0; n < 1850; n++) begin
         if ($urandom_range(0, 1) == 0)
            add_request(pifp_pkg::FUNC_ENCODE,
                        ($urandom_range(0, 9) == 0) ? random_word() : random_double(),
                        ($urandom_range(0, 9) == 0) ? random_word() : random_double(),
                        pifp_pkg::IDX_W'($urandom()));
         else
            add_request(pifp_pkg::FUNC_DECODE,
                        ($urandom_range(0, 4) == 0) ? random_word() : random_packed(),
                        ($urandom_range(0, 4) == 0) ? random_word() : random_packed(),
                        pifp_pkg::IDX_W'($urandom()));
      end
      total_items = queued_requests.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items)
         @(posedge clock);
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d transactions checked: %0d encode, %0d decode, under random stalls",
               checked_count, encode_count, decode_count);
      if (error_count == 0 && awaited_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches, %0d results outstanding", error_count,
                  awaited_results.size());
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("timeout with %0d of %0d transactions accepted", accepted_count, total_items);
      $display("simulation failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/pifp_pkg.sv
sv/pifp_conv.sv
sv/patch_index_fixed_point_pack_unit.sv
sim/patch_index_fixed_point_pack_unit_tb.sv
